>>> rtl/vcmd_pkg.sv
// vcmd_pkg: shared types, codes and constants of the voxel column map decoder
// no dependencies; imported by every rtl module of the block
`default_nettype none

package vcmd_pkg;

	localparam int MAX_SIDE    = 8192;
	localparam int MAX_LEVELS  = 64;
	localparam int DEPTH_LIMIT = 128;
	localparam int CHUNK_BITS  = 16;
	localparam int NUM_CHUNKS  = 4;

	localparam logic [31:0] SIGNATURE = 32'h1145148a;

	typedef enum logic [2:0] {
		ST_COLUMN  = 3'd0,
		ST_BAD_SIG = 3'd1,
		ST_BAD_DIM = 3'd2,
		ST_DEPTH   = 3'd3,
		ST_BAD_Z   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_HEAD = 3'd0,
		PH_FMT  = 3'd1,
		PH_RLE  = 3'd2,
		PH_BLO  = 3'd3,
		PH_BHI  = 3'd4,
		PH_IDLE = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_map;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] column_bits;
		logic [12:0] col_x;
		logic [12:0] col_y;
		logic        last_column;
	} result_t;

	// handshake control between the stages
	typedef struct packed {
		logic s1_valid;
		logic advance;
	} pipe_ctl_t;

endpackage

`default_nettype wire

>>> rtl/vcmd_in_if.sv
// vcmd_in_if: input channel carrying one map stream byte per item
// no dependencies
`default_nettype none

interface vcmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       new_map;

	modport source (output valid, output in_byte, output new_map, input ready);
	modport sink   (input valid, input in_byte, input new_map, output ready);
endinterface

`default_nettype wire

>>> rtl/vcmd_out_if.sv
// vcmd_out_if: output channel carrying one decoded column or error per item
// no dependencies
`default_nettype none

interface vcmd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] column_bits;
	logic [12:0] col_x;
	logic [12:0] col_y;
	logic        last_column;

	modport source (output valid, output status, output column_bits, output col_x,
		output col_y, output last_column, input ready);
	modport sink   (input valid, input status, input column_bits, input col_x,
		input col_y, input last_column, output ready);
endinterface

`default_nettype wire

>>> rtl/voxel_column_map_decoder_top.sv
// voxel_column_map_decoder_top: header check and column decode of an inflated map stream
// depends on vcmd_pkg, vcmd_in_if, vcmd_out_if, vcmd_in_stage, vcmd_core, vcmd_out_stage
//
//   channel  dir  payload                                        item
//   in_ch    in   in_byte[7:0], new_map                          one stream byte
//   out_ch   out  status[2:0], column_bits[63:0], col_x, col_y,  one column or error
//                 last_column
//
// one byte accepted per cycle while no held result stalls the input
// all decode work sits between the input register and the result register
// arst_n clears the parse state; parsing of a header starts at once
// a held result stalls the input only when the input register is also full
`default_nettype none

module voxel_column_map_decoder_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	vcmd_in_if.sink    in_ch,
	vcmd_out_if.source out_ch
);
	import vcmd_pkg::*;

	item_t     item_s1;
	logic      valid_s1;
	logic      advance;
	pipe_ctl_t ctl;
	logic      res_valid;
	result_t   res;

	assign ctl.s1_valid = valid_s1;
	assign ctl.advance  = advance;

	vcmd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.item_s1  (item_s1),
		.valid_s1 (valid_s1)
	);

	vcmd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	vcmd_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

>>> rtl/vcmd_in_stage.sv
// vcmd_in_stage: input register of the decoder, takes one byte per cycle while empty or advancing
// depends on vcmd_pkg and vcmd_in_if
`default_nettype none

module vcmd_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	vcmd_in_if.sink             in_ch,
	input  wire logic           advance,
	output vcmd_pkg::item_t     item_s1,
	output logic                valid_s1
);
	import vcmd_pkg::*;

	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.in_byte <= in_ch.in_byte;
			item_s1.new_map <= in_ch.new_map;
		end
	end

endmodule

`default_nettype wire

>>> rtl/vcmd_core.sv
// vcmd_core: parse state and single pass decode of one stream byte
// depends on vcmd_pkg
`default_nettype none

module vcmd_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire vcmd_pkg::pipe_ctl_t ctl,
	input  wire vcmd_pkg::item_t     item_s1,
	output logic                     res_valid,
	output vcmd_pkg::result_t        res
);
	import vcmd_pkg::*;

	phase_t      phase_q;
	logic [3:0]  header_count_q;
	logic [31:0] sig_shift_q;
	logic [15:0] map_width_q;
	logic [15:0] map_height_q;
	logic [15:0] map_depth_q;
	logic [6:0]  level_q;
	logic        fill_run_q;
	logic [63:0] column_acc_q;
	logic [3:0]  chunk_mask_q;
	logic [1:0]  chunk_index_q;
	logic [7:0]  low_hold_q;
	logic [12:0] pos_x_q;
	logic [12:0] pos_y_q;
	logic [12:0] row_count_q;
	logic        error_hold_q;

	phase_t      phase_d;
	logic [3:0]  header_count_d;
	logic [31:0] sig_shift_d;
	logic [15:0] map_width_d;
	logic [15:0] map_height_d;
	logic [15:0] map_depth_d;
	logic [6:0]  level_d;
	logic        fill_run_d;
	logic [63:0] column_acc_d;
	logic [3:0]  chunk_mask_d;
	logic [1:0]  chunk_index_d;
	logic [7:0]  low_hold_d;
	logic [12:0] pos_x_d;
	logic [12:0] pos_y_d;
	logic [12:0] row_count_d;
	logic        error_hold_d;

	logic        take;
	logic [7:0]  b;
	phase_t      cur_phase;
	logic [3:0]  cur_count;
	logic [31:0] cur_sig;
	logic        cur_err;
	logic        active;
	logic [3:0]  count_nx;
	logic [31:0] sig_nx;
	logic [15:0] width_nx;
	logic [15:0] height_nx;
	logic [15:0] depth_nx;

	logic [7:0]  run_end;
	logic        run_fill;
	logic        run_bad;
	logic [63:0] run_acc;
	logic        run_done;

	logic [3:0]  fmt_mask;
	logic        nc0_found;
	logic [1:0]  nc0_idx;
	logic [63:0] word_acc;
	logic        nc1_found;
	logic [1:0]  nc1_idx;

	logic        emit_err;
	status_t     err_code;
	logic        emit_col;
	logic [63:0] col_acc;
	logic        last_in_row;
	logic        last_row;

	function automatic logic [63:0] below(input logic [6:0] n);
		logic [63:0] m;
		if (n[6]) begin
			m = '1;
		end else begin
			m = (64'd1 << n[5:0]) - 64'd1;
		end
		return m;
	endfunction

	// first flagged chunk at or after start that begins below the depth
	function automatic logic [2:0] next_chunk(input logic [2:0] start,
		input logic [3:0] mask, input logic [15:0] depth);
		logic       found;
		logic [1:0] idx;
		found = 1'b0;
		idx   = '0;
		for (int c = 0; c < NUM_CHUNKS; c++) begin
			if (!found && 3'(c) >= start && 16'(c * CHUNK_BITS) < depth && mask[c]) begin
				found = 1'b1;
				idx   = 2'(c);
			end
		end
		return {found, idx};
	endfunction

	assign take      = ctl.s1_valid && ctl.advance;
	assign b         = item_s1.in_byte;
	assign cur_phase = item_s1.new_map ? PH_HEAD : phase_q;
	assign cur_count = item_s1.new_map ? 4'd0 : header_count_q;
	assign cur_sig   = item_s1.new_map ? 32'd0 : sig_shift_q;
	assign cur_err   = item_s1.new_map ? 1'b0 : error_hold_q;
	assign active    = take && !cur_err && cur_phase != PH_IDLE;

	// header fields
	assign count_nx  = cur_count + 4'd1;
	assign sig_nx    = (cur_count < 4'd4) ? {b, cur_sig[31:8]} : cur_sig;
	assign width_nx  = (cur_count == 4'd4) ? {8'd0, b} :
		(cur_count == 4'd5) ? {b, map_width_q[7:0]} : map_width_q;
	assign height_nx = (cur_count == 4'd6) ? {8'd0, b} :
		(cur_count == 4'd7) ? {b, map_height_q[7:0]} : map_height_q;
	assign depth_nx  = (cur_count == 4'd8) ? {8'd0, b} :
		(cur_count == 4'd9) ? {b, map_depth_q[7:0]} : map_depth_q;

	// run-length byte
	assign run_end  = b[7] ? {1'b0, b[6:0]} : b;
	assign run_fill = b[7] || fill_run_q;
	assign run_bad  = (run_end <= {1'b0, level_q}) || ({8'd0, run_end} > map_depth_q);
	assign run_acc  = column_acc_q |
		(run_fill ? (below(run_end[6:0]) & ~below(level_q)) : 64'd0);
	assign run_done = {9'd0, run_end[6:0]} >= map_depth_q;

	// bitmap bytes
	assign fmt_mask = b[4:1];
	assign {nc0_found, nc0_idx} = next_chunk(3'd0, fmt_mask, map_depth_q);
	assign {nc1_found, nc1_idx} = next_chunk({1'b0, chunk_index_q} + 3'd1,
		chunk_mask_q, map_depth_q);

	always_comb begin
		unique case (chunk_index_q)
			2'd0: word_acc = column_acc_q | {48'd0, b, low_hold_q};
			2'd1: word_acc = column_acc_q | {32'd0, b, low_hold_q, 16'd0};
			2'd2: word_acc = column_acc_q | {16'd0, b, low_hold_q, 32'd0};
			2'd3: word_acc = column_acc_q | {b, low_hold_q, 48'd0};
			default: word_acc = column_acc_q;
		endcase
	end

	assign last_in_row = ({3'd0, row_count_q} + 16'd1) >= map_width_q;
	assign last_row    = ({3'd0, pos_y_q} + 16'd1) >= map_height_q;

	// result decision
	always_comb begin
		emit_err = 1'b0;
		err_code = ST_BAD_SIG;
		emit_col = 1'b0;
		col_acc  = column_acc_q;
		if (active) begin
			unique case (cur_phase)
				PH_HEAD: begin
					if (count_nx == 4'd4 && sig_nx != SIGNATURE) begin
						emit_err = 1'b1;
						err_code = ST_BAD_SIG;
					end else if (count_nx == 4'd10) begin
						if (width_nx == 16'd0 || height_nx == 16'd0 || depth_nx == 16'd0 ||
							width_nx > 16'(MAX_SIDE) || height_nx > 16'(MAX_SIDE) ||
							depth_nx > 16'(DEPTH_LIMIT)) begin
							emit_err = 1'b1;
							err_code = ST_BAD_DIM;
						end else if (depth_nx > 16'(MAX_LEVELS)) begin
							emit_err = 1'b1;
							err_code = ST_DEPTH;
						end
					end
				end
				PH_FMT: begin
					col_acc  = '0;
					emit_col = b[0] && !nc0_found;
				end
				PH_RLE: begin
					if (run_bad) begin
						emit_err = 1'b1;
						err_code = ST_BAD_Z;
					end else begin
						col_acc  = run_acc;
						emit_col = run_done;
					end
				end
				PH_BHI: begin
					col_acc  = word_acc;
					emit_col = !nc1_found;
				end
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d        = phase_q;
		header_count_d = header_count_q;
		sig_shift_d    = sig_shift_q;
		map_width_d    = map_width_q;
		map_height_d   = map_height_q;
		map_depth_d    = map_depth_q;
		level_d        = level_q;
		fill_run_d     = fill_run_q;
		column_acc_d   = column_acc_q;
		chunk_mask_d   = chunk_mask_q;
		chunk_index_d  = chunk_index_q;
		low_hold_d     = low_hold_q;
		pos_x_d        = pos_x_q;
		pos_y_d        = pos_y_q;
		row_count_d    = row_count_q;
		error_hold_d   = error_hold_q;

		if (take && item_s1.new_map) begin
			phase_d        = PH_HEAD;
			header_count_d = '0;
			sig_shift_d    = '0;
			map_width_d    = '0;
			map_height_d   = '0;
			map_depth_d    = '0;
			level_d        = '0;
			fill_run_d     = 1'b0;
			column_acc_d   = '0;
			chunk_mask_d   = '0;
			chunk_index_d  = '0;
			low_hold_d     = '0;
			pos_x_d        = '0;
			pos_y_d        = '0;
			row_count_d    = '0;
			error_hold_d   = 1'b0;
		end

		if (active) begin
			unique case (cur_phase)
				PH_HEAD: begin
					header_count_d = count_nx;
					sig_shift_d    = sig_nx;
					map_width_d    = width_nx;
					map_height_d   = height_nx;
					map_depth_d    = depth_nx;
					if (count_nx == 4'd10 && !emit_err) begin
						pos_x_d     = '0;
						pos_y_d     = '0;
						row_count_d = '0;
						phase_d     = PH_FMT;
					end
				end
				PH_FMT: begin
					column_acc_d = '0;
					if (!b[0]) begin
						level_d    = '0;
						fill_run_d = 1'b0;
						phase_d    = PH_RLE;
					end else begin
						chunk_mask_d = fmt_mask;
						if (nc0_found) begin
							chunk_index_d = nc0_idx;
							phase_d       = PH_BLO;
						end
					end
				end
				PH_RLE: begin
					if (!run_bad) begin
						column_acc_d = run_acc;
						level_d      = run_end[6:0];
						fill_run_d   = !run_fill;
					end
				end
				PH_BLO: begin
					low_hold_d = b;
					phase_d    = PH_BHI;
				end
				PH_BHI: begin
					column_acc_d = word_acc;
					if (nc1_found) begin
						chunk_index_d = nc1_idx;
						phase_d       = PH_BLO;
					end
				end
				default: begin
				end
			endcase

			if (emit_err) begin
				error_hold_d = 1'b1;
				phase_d      = PH_IDLE;
			end

			if (emit_col) begin
				if (last_in_row) begin
					row_count_d = '0;
					if (last_row) begin
						phase_d = PH_IDLE;
					end else begin
						pos_y_d = pos_y_q + 13'd1;
						pos_x_d = (!pos_y_q[0]) ? 13'(map_width_q - 16'd1) : 13'd0;
						phase_d = PH_FMT;
					end
				end else begin
					row_count_d = row_count_q + 13'd1;
					pos_x_d     = pos_y_q[0] ? (pos_x_q - 13'd1) : (pos_x_q + 13'd1);
					phase_d     = PH_FMT;
				end
			end
		end
	end

	// result outputs
	always_comb begin
		res_valid       = emit_err || emit_col;
		res.status      = emit_err ? err_code : ST_COLUMN;
		res.column_bits = emit_err ? 64'd0 : col_acc;
		res.col_x       = emit_err ? 13'd0 : pos_x_q;
		res.col_y       = emit_err ? 13'd0 : pos_y_q;
		res.last_column = !emit_err && last_in_row && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEAD;
			header_count_q <= '0;
			sig_shift_q    <= '0;
			map_width_q    <= '0;
			map_height_q   <= '0;
			map_depth_q    <= '0;
			level_q        <= '0;
			fill_run_q     <= 1'b0;
			column_acc_q   <= '0;
			chunk_mask_q   <= '0;
			chunk_index_q  <= '0;
			low_hold_q     <= '0;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			row_count_q    <= '0;
			error_hold_q   <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			header_count_q <= header_count_d;
			sig_shift_q    <= sig_shift_d;
			map_width_q    <= map_width_d;
			map_height_q   <= map_height_d;
			map_depth_q    <= map_depth_d;
			level_q        <= level_d;
			fill_run_q     <= fill_run_d;
			column_acc_q   <= column_acc_d;
			chunk_mask_q   <= chunk_mask_d;
			chunk_index_q  <= chunk_index_d;
			low_hold_q     <= low_hold_d;
			pos_x_q        <= pos_x_d;
			pos_y_q        <= pos_y_d;
			row_count_q    <= row_count_d;
			error_hold_q   <= error_hold_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/vcmd_out_stage.sv
// vcmd_out_stage: result register of the decoder, holds an item until taken
// depends on vcmd_pkg and vcmd_out_if
`default_nettype none

module vcmd_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_valid,
	input  wire vcmd_pkg::result_t res,
	output logic                   advance,
	vcmd_out_if.source             out_ch
);
	import vcmd_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	assign advance = !valid_s2 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid       = valid_s2;
	assign out_ch.status      = res_s2.status;
	assign out_ch.column_bits = res_s2.column_bits;
	assign out_ch.col_x       = res_s2.col_x;
	assign out_ch.col_y       = res_s2.col_y;
	assign out_ch.last_column = res_s2.last_column;

endmodule

`default_nettype wire
